// ===== src/spp_pkg.sv =====
`timescale 1ns / 1ps
package spp_pkg;

	localparam int CW        = 32;
	localparam int FRAC_BITS = 4;
	localparam int DW        = CW + 1;
	localparam int DOTW      = 2 * DW + 2;
	localparam int BW        = 2 * DOTW + 2;
	localparam int QW        = 33;
	localparam int OFFW      = DW + QW + 1;
	localparam int SEPW      = 32;
	localparam int SQW       = 2 * SEPW;
	localparam int IDXW      = 2;
	localparam int HW        = DOTW / 2;

	localparam logic [QW-1:0] ONE_Q = {1'b1, {(QW-1){1'b0}}};

	localparam int CD_RAW = 100 << FRAC_BITS;
	localparam logic [15:0] CD_RESET = (CD_RAW > 65535) ? 16'hFFFF : 16'(CD_RAW);
	localparam logic [15:0] CT_RESET = 16'(1 << FRAC_BITS);

	localparam logic [IDXW-1:0] REG_CONFLICT = 2'd0;
	localparam logic [IDXW-1:0] REG_CROSSING = 2'd1;
	localparam logic [IDXW-1:0] REG_DEGEN    = 2'd2;

	typedef logic signed [CW-1:0]   coord_t;
	typedef logic signed [DW-1:0]   diff_t;
	typedef logic signed [DOTW-1:0] dot_t;
	typedef logic signed [BW-1:0]   big_t;
	typedef logic signed [OFFW-1:0] off_t;
	typedef logic [QW-1:0]          q_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} dvec_t;

	typedef struct packed {
		logic [15:0] conflict_distance;
		logic [15:0] crossing_tolerance;
		logic [15:0] degenerate_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [2*HW-1:0] hh;
		logic signed [2*HW:0]   hl;
		logic signed [2*HW:0]   lh;
		logic signed [2*HW+1:0] ll;
	} pp_t;

	typedef struct packed {
		logic signed [HW+QW:0]   hq;
		logic signed [HW+QW+1:0] lq;
	} qpp_t;

	typedef struct packed {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_start_z;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t a_end_z;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_start_z;
		coord_t b_end_x;
		coord_t b_end_y;
		coord_t b_end_z;
	} in_item_t;

	typedef struct packed {
		logic            conflict;
		logic            crossing;
		logic [SEPW-1:0] separation;
		coord_t          mid_x;
		coord_t          mid_y;
		coord_t          mid_z;
		coord_t          near_a_x;
		coord_t          near_a_y;
		coord_t          near_a_z;
		coord_t          near_b_x;
		coord_t          near_b_y;
		coord_t          near_b_z;
	} out_item_t;

	function automatic diff_t dsub(input coord_t a, input coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	function automatic dot_t pmul(input diff_t a, input diff_t b);
		logic signed [2*DW-1:0] p;
		p = a * b;
		return dot_t'(p);
	endfunction

	// split a wide product into half-width partial products
	function automatic pp_t bpart(input dot_t a, input dot_t b);
		logic signed [HW-1:0] ah;
		logic signed [HW-1:0] bh;
		logic signed [HW:0]   al;
		logic signed [HW:0]   bl;
		pp_t                  p;
		ah   = a[DOTW-1:HW];
		bh   = b[DOTW-1:HW];
		al   = {1'b0, a[HW-1:0]};
		bl   = {1'b0, b[HW-1:0]};
		p.hh = ah * bh;
		p.hl = ah * bl;
		p.lh = al * bh;
		p.ll = al * bl;
		return p;
	endfunction

	function automatic big_t bsum(input pp_t p);
		return (big_t'(p.hh) <<< (2 * HW)) + ((big_t'(p.hl) + big_t'(p.lh)) <<< HW) +
		       big_t'(p.ll);
	endfunction

	function automatic qpp_t qpart(input dot_t a, input q_t q);
		logic signed [HW-1:0] ah;
		logic signed [HW:0]   al;
		logic signed [QW:0]   qs;
		qpp_t                 p;
		ah   = a[DOTW-1:HW];
		al   = {1'b0, a[HW-1:0]};
		qs   = {1'b0, q};
		p.hq = ah * qs;
		p.lq = al * qs;
		return p;
	endfunction

	function automatic big_t qsum(input qpp_t p);
		return (big_t'(p.hq) <<< HW) + big_t'(p.lq);
	endfunction

	function automatic off_t smul(input diff_t d, input q_t q);
		off_t p;
		p = d * $signed({1'b0, q});
		return p;
	endfunction

	function automatic coord_t point(input coord_t s, input off_t p);
		off_t r;
		r = (p + (off_t'(1) <<< (QW - 2))) >>> (QW - 1);
		r = r + off_t'(s);
		return coord_t'(r);
	endfunction

	function automatic coord_t midpoint(input coord_t a, input coord_t b);
		diff_t s;
		s = diff_t'(a) + diff_t'(b);
		s = s >>> 1;
		return coord_t'(s);
	endfunction

	function automatic logic apart(input coord_t sa, input coord_t ea, input coord_t sb,
		input coord_t eb, input logic [15:0] cd);
		coord_t lo_a;
		coord_t hi_a;
		coord_t lo_b;
		coord_t hi_b;
		diff_t  g;
		lo_a = (sa < ea) ? sa : ea;
		hi_a = (sa > ea) ? sa : ea;
		lo_b = (sb < eb) ? sb : eb;
		hi_b = (sb > eb) ? sb : eb;
		g = diff_t'({cd, 1'b0});
		return (dsub(lo_a, hi_b) > g) || (dsub(lo_b, hi_a) > g);
	endfunction

endpackage

// ===== src/spp_div.sv =====
`timescale 1ns / 1ps
module spp_div import spp_pkg::*; #(
	parameter int W     = BW,
	parameter int STEPS = QW,
	parameter int SW    = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	input  logic [SW-1:0]       side_in,
	output logic                out_valid,
	output logic [STEPS-1:0]    quo,
	output logic [SW-1:0]       side_out
);

	logic                v_s    [STEPS];
	logic signed [W-1:0] rem_s  [STEPS];
	logic signed [W-1:0] den_s  [STEPS];
	logic [STEPS-1:0]    q_s    [STEPS];
	logic                zero_s [STEPS];
	logic                one_s  [STEPS];
	logic [SW-1:0]       side_s [STEPS];
	logic [W:0]          nxt    [STEPS];
	logic [STEPS:0]      rnd;

	function automatic logic [W:0] div_step(input logic signed [W-1:0] rem,
		input logic signed [W-1:0] d);
		logic signed [W-1:0] r2;
		logic                ge;
		r2 = rem <<< 1;
		ge = (r2 >= d);
		return {ge, ge ? r2 - d : r2};
	endfunction

	always_comb begin
		nxt[0] = div_step(num, den);
		for (int k = 1; k < STEPS; k++) begin
			nxt[k] = div_step(rem_s[k-1], den_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			v_s[0] <= in_valid;
			for (int k = 1; k < STEPS; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= nxt[0][W-1:0];
		q_s[0]    <= STEPS'(nxt[0][W]);
		den_s[0]  <= den;
		zero_s[0] <= (num <= 0) || (den <= 0);
		one_s[0]  <= (num >= den);
		side_s[0] <= side_in;
		for (int k = 1; k < STEPS; k++) begin
			rem_s[k]  <= nxt[k][W-1:0];
			q_s[k]    <= {q_s[k-1][STEPS-2:0], nxt[k][W]};
			den_s[k]  <= den_s[k-1];
			zero_s[k] <= zero_s[k-1];
			one_s[k]  <= one_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	assign rnd       = {1'b0, q_s[STEPS-1]} + 1'b1;
	assign out_valid = v_s[STEPS-1];
	assign side_out  = side_s[STEPS-1];
	assign quo       = zero_s[STEPS-1] ? '0 :
	                   one_s[STEPS-1]  ? {1'b1, {(STEPS-1){1'b0}}} : rnd[STEPS:1];

endmodule

// ===== src/spp_sqrt.sv =====
`timescale 1ns / 1ps
module spp_sqrt import spp_pkg::*; #(
	parameter int XW = SQW,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [XW-1:0]   x_in,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [XW/2-1:0] root,
	output logic [SW-1:0]   side_out
);

	localparam int RW = XW / 2;

	logic            v_s    [RW];
	logic [XW-1:0]   x_s    [RW];
	logic [XW-1:0]   r_s    [RW];
	logic [SW-1:0]   side_s [RW];
	logic [2*XW-1:0] nxt    [RW];

	function automatic logic [2*XW-1:0] sq_step(input logic [XW-1:0] x,
		input logic [XW-1:0] r, input logic [XW-1:0] b);
		logic [XW-1:0] t;
		t = r + b;
		if (x >= t) begin
			return {x - t, (r >> 1) + b};
		end
		return {x, r >> 1};
	endfunction

	always_comb begin
		nxt[0] = sq_step(x_in, '0, XW'(1) << (XW - 2));
		for (int k = 1; k < RW; k++) begin
			nxt[k] = sq_step(x_s[k-1], r_s[k-1], XW'(1) << (XW - 2 - 2 * k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RW; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			v_s[0] <= in_valid;
			for (int k = 1; k < RW; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= nxt[0][2*XW-1:XW];
		r_s[0]    <= nxt[0][XW-1:0];
		side_s[0] <= side_in;
		for (int k = 1; k < RW; k++) begin
			x_s[k]    <= nxt[k][2*XW-1:XW];
			r_s[k]    <= nxt[k][XW-1:0];
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = v_s[RW-1];
	assign root      = r_s[RW-1][RW-1:0];
	assign side_out  = side_s[RW-1];

endmodule

// ===== src/segment_pair_proximity_check.sv =====
`timescale 1ns / 1ps
// Throughput: one item per clock; busy is low except in the first cycle after reset.
// Two 33-stage parameter dividers and a 32-stage square root set the depth.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// Results appear for one cycle on done and cannot be held off.
module segment_pair_proximity_check import spp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  in_item_t        item,
	output logic            done,
	output out_item_t       result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [IDXW-1:0] cfg_index,
	input  logic [15:0]     cfg_data
);

	localparam int LATENCY = 6 + QW + 3 + QW + 5 + SEPW + 1;

	localparam logic [1:0] MODE_MID  = 2'd0;
	localparam logic [1:0] MODE_NEG  = 2'd1;
	localparam logic [1:0] MODE_OVER = 2'd2;

	typedef struct packed {
		vec_t  sa;
		vec_t  sb;
		dvec_t da;
		dvec_t db;
		dot_t  aa;
		dot_t  bb;
		dot_t  ab;
		dot_t  ac;
		dot_t  bc;
		logic  pta;
		logic  ptb;
		logic  ovl;
	} side1_t;

	typedef struct packed {
		vec_t       sa;
		vec_t       sb;
		dvec_t      da;
		dvec_t      db;
		q_t         q1;
		logic [1:0] mode;
		logic       pta;
		logic       ptb;
		logic       ovl;
	} side2_t;

	typedef struct packed {
		vec_t pa;
		vec_t pb;
		vec_t mid;
		logic conflict;
		logic crossing;
		logic big;
		logic ovl;
	} side3_t;

	cfg_t      cfg_q;
	logic      busy_q;
	logic      done_q;
	out_item_t result_q;
	logic      fire;

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic  v_s13, v_s14;

	vec_t  sa_s1, sb_s1;
	dvec_t da_s1, db_s1, dc_s1;
	logic  ovl_s1;

	vec_t  sa_s2, sb_s2;
	dvec_t da_s2, db_s2;
	logic  ovl_s2;
	dot_t  paa_s2 [3];
	dot_t  pbb_s2 [3];
	dot_t  pab_s2 [3];
	dot_t  pac_s2 [3];
	dot_t  pbc_s2 [3];

	vec_t  sa_s3, sb_s3;
	dvec_t da_s3, db_s3;
	logic  ovl_s3;
	dot_t  aa_s3, bb_s3, ab_s3, ac_s3, bc_s3;

	side1_t sd_s4;
	pp_t    aabb_s4, abab_s4, abbc_s4, bbac_s4;

	side1_t sd_s5;
	big_t   aabb_s5, abab_s5, abbc_s5, bbac_s5;

	side1_t sd_s6;
	big_t   n1_s6, d1_s6;
	big_t   den_c, num_c, n1_c, d1_c;

	logic   v_d1;
	q_t     q1;
	logic [$bits(side1_t)-1:0] sd1_raw;
	side1_t sd_d1;

	side1_t sd_s7;
	q_t     q1_s7;
	qpp_t   abq_s7;

	side1_t sd_s8;
	q_t     q1_s8;
	big_t   abq_s8;

	side2_t sd_s9;
	big_t   n2_s9, d2_s9;
	big_t   nt_c, dt_c, n2_c, d2_c;
	logic [1:0] mode_c;

	logic   v_d2;
	q_t     q2;
	logic [$bits(side2_t)-1:0] sd2_raw;
	side2_t sd_d2;

	q_t     s_c, t_c;
	vec_t   sa_s10, sb_s10;
	logic   ovl_s10;
	off_t   oa_s10 [3];
	off_t   ob_s10 [3];

	vec_t   pa_s11, pb_s11;
	logic   ovl_s11;

	vec_t   pa_s12, pb_s12, mid_s12;
	dvec_t  d_s12;
	logic   ovl_s12;

	vec_t   pa_s13, pb_s13, mid_s13;
	dot_t   sq_s13 [3];
	logic   ovl_s13;

	side3_t sd_s14;
	logic [SQW-1:0] x_s14;
	dot_t   dsq_c;
	logic [31:0] cd2_c, ct2_c;

	logic   v_sq;
	logic [SEPW-1:0] root;
	logic [$bits(side3_t)-1:0] sd3_raw;
	side3_t sd_sq;

	assign fire      = start && !busy;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q                   <= 1'b1;
			cfg_q.conflict_distance  <= CD_RESET;
			cfg_q.crossing_tolerance <= CT_RESET;
			cfg_q.degenerate_limit   <= '0;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CONFLICT: cfg_q.conflict_distance  <= cfg_data;
					REG_CROSSING: cfg_q.crossing_tolerance <= cfg_data;
					REG_DEGEN:    cfg_q.degenerate_limit   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			v_s10  <= 1'b0;
			v_s11  <= 1'b0;
			v_s12  <= 1'b0;
			v_s13  <= 1'b0;
			v_s14  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= fire;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_d1;
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			v_s10  <= v_d2;
			v_s11  <= v_s10;
			v_s12  <= v_s11;
			v_s13  <= v_s12;
			v_s14  <= v_s13;
			done_q <= v_sq;
		end
	end

	// differences and grown-box test
	always_ff @(posedge clk) begin
		sa_s1  <= '{item.a_start_x, item.a_start_y, item.a_start_z};
		sb_s1  <= '{item.b_start_x, item.b_start_y, item.b_start_z};
		da_s1  <= '{dsub(item.a_end_x, item.a_start_x), dsub(item.a_end_y, item.a_start_y),
		           dsub(item.a_end_z, item.a_start_z)};
		db_s1  <= '{dsub(item.b_end_x, item.b_start_x), dsub(item.b_end_y, item.b_start_y),
		           dsub(item.b_end_z, item.b_start_z)};
		dc_s1  <= '{dsub(item.a_start_x, item.b_start_x),
		           dsub(item.a_start_y, item.b_start_y),
		           dsub(item.a_start_z, item.b_start_z)};
		ovl_s1 <= !(apart(item.a_start_x, item.a_end_x, item.b_start_x, item.b_end_x,
		                  cfg_q.conflict_distance) ||
		            apart(item.a_start_y, item.a_end_y, item.b_start_y, item.b_end_y,
		                  cfg_q.conflict_distance) ||
		            apart(item.a_start_z, item.a_end_z, item.b_start_z, item.b_end_z,
		                  cfg_q.conflict_distance));
	end

	// per-axis products
	always_ff @(posedge clk) begin
		sa_s2     <= sa_s1;
		sb_s2     <= sb_s1;
		da_s2     <= da_s1;
		db_s2     <= db_s1;
		ovl_s2    <= ovl_s1;
		paa_s2[0] <= pmul(da_s1.x, da_s1.x);
		paa_s2[1] <= pmul(da_s1.y, da_s1.y);
		paa_s2[2] <= pmul(da_s1.z, da_s1.z);
		pbb_s2[0] <= pmul(db_s1.x, db_s1.x);
		pbb_s2[1] <= pmul(db_s1.y, db_s1.y);
		pbb_s2[2] <= pmul(db_s1.z, db_s1.z);
		pab_s2[0] <= pmul(da_s1.x, db_s1.x);
		pab_s2[1] <= pmul(da_s1.y, db_s1.y);
		pab_s2[2] <= pmul(da_s1.z, db_s1.z);
		pac_s2[0] <= pmul(da_s1.x, dc_s1.x);
		pac_s2[1] <= pmul(da_s1.y, dc_s1.y);
		pac_s2[2] <= pmul(da_s1.z, dc_s1.z);
		pbc_s2[0] <= pmul(db_s1.x, dc_s1.x);
		pbc_s2[1] <= pmul(db_s1.y, dc_s1.y);
		pbc_s2[2] <= pmul(db_s1.z, dc_s1.z);
	end

	// dot products
	always_ff @(posedge clk) begin
		sa_s3  <= sa_s2;
		sb_s3  <= sb_s2;
		da_s3  <= da_s2;
		db_s3  <= db_s2;
		ovl_s3 <= ovl_s2;
		aa_s3  <= paa_s2[0] + paa_s2[1] + paa_s2[2];
		bb_s3  <= pbb_s2[0] + pbb_s2[1] + pbb_s2[2];
		ab_s3  <= pab_s2[0] + pab_s2[1] + pab_s2[2];
		ac_s3  <= pac_s2[0] + pac_s2[1] + pac_s2[2];
		bc_s3  <= pbc_s2[0] + pbc_s2[1] + pbc_s2[2];
	end

	// partial products of the dot cross terms, point-segment flags
	always_ff @(posedge clk) begin
		sd_s4.sa  <= sa_s3;
		sd_s4.sb  <= sb_s3;
		sd_s4.da  <= da_s3;
		sd_s4.db  <= db_s3;
		sd_s4.aa  <= aa_s3;
		sd_s4.bb  <= bb_s3;
		sd_s4.ab  <= ab_s3;
		sd_s4.ac  <= ac_s3;
		sd_s4.bc  <= bc_s3;
		sd_s4.pta <= aa_s3 <= dot_t'(cfg_q.degenerate_limit);
		sd_s4.ptb <= bb_s3 <= dot_t'(cfg_q.degenerate_limit);
		sd_s4.ovl <= ovl_s3;
		aabb_s4   <= bpart(aa_s3, bb_s3);
		abab_s4   <= bpart(ab_s3, ab_s3);
		abbc_s4   <= bpart(ab_s3, bc_s3);
		bbac_s4   <= bpart(bb_s3, ac_s3);
	end

	// combine the partial products
	always_ff @(posedge clk) begin
		sd_s5   <= sd_s4;
		aabb_s5 <= bsum(aabb_s4);
		abab_s5 <= bsum(abab_s4);
		abbc_s5 <= bsum(abbc_s4);
		bbac_s5 <= bsum(bbac_s4);
	end

	// pick the first division by case
	always_comb begin
		den_c = aabb_s5 - abab_s5;
		num_c = abbc_s5 - bbac_s5;
		if (sd_s5.pta && sd_s5.ptb) begin
			n1_c = '0;
			d1_c = '0;
		end else if (sd_s5.pta) begin
			n1_c = big_t'(sd_s5.bc);
			d1_c = big_t'(sd_s5.bb);
		end else if (sd_s5.ptb) begin
			n1_c = -big_t'(sd_s5.ac);
			d1_c = big_t'(sd_s5.aa);
		end else begin
			n1_c = num_c;
			d1_c = (den_c > big_t'(cfg_q.degenerate_limit)) ? den_c : '0;
		end
	end

	always_ff @(posedge clk) begin
		sd_s6 <= sd_s5;
		n1_s6 <= n1_c;
		d1_s6 <= d1_c;
	end

	spp_div #(
		.W     (BW),
		.STEPS (QW),
		.SW    ($bits(side1_t))
	) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.num       (n1_s6),
		.den       (d1_s6),
		.side_in   (sd_s6),
		.out_valid (v_d1),
		.quo       (q1),
		.side_out  (sd1_raw)
	);

	assign sd_d1 = side1_t'(sd1_raw);

	always_ff @(posedge clk) begin
		sd_s7  <= sd_d1;
		q1_s7  <= q1;
		abq_s7 <= qpart(sd_d1.ab, q1);
	end

	always_ff @(posedge clk) begin
		sd_s8  <= sd_s7;
		q1_s8  <= q1_s7;
		abq_s8 <= qsum(abq_s7);
	end

	// clamp of the B parameter selects the second division
	always_comb begin
		nt_c = abq_s8 + (big_t'(sd_s8.bc) <<< (QW - 1));
		dt_c = big_t'(sd_s8.bb) <<< (QW - 1);
		if (nt_c < 0) begin
			mode_c = MODE_NEG;
			n2_c   = -big_t'(sd_s8.ac);
			d2_c   = big_t'(sd_s8.aa);
		end else if (nt_c > dt_c) begin
			mode_c = MODE_OVER;
			n2_c   = big_t'(sd_s8.ab) - big_t'(sd_s8.ac);
			d2_c   = big_t'(sd_s8.aa);
		end else begin
			mode_c = MODE_MID;
			n2_c   = nt_c;
			d2_c   = dt_c;
		end
	end

	always_ff @(posedge clk) begin
		sd_s9.sa   <= sd_s8.sa;
		sd_s9.sb   <= sd_s8.sb;
		sd_s9.da   <= sd_s8.da;
		sd_s9.db   <= sd_s8.db;
		sd_s9.q1   <= q1_s8;
		sd_s9.mode <= mode_c;
		sd_s9.pta  <= sd_s8.pta;
		sd_s9.ptb  <= sd_s8.ptb;
		sd_s9.ovl  <= sd_s8.ovl;
		n2_s9      <= n2_c;
		d2_s9      <= d2_c;
	end

	spp_div #(
		.W     (BW),
		.STEPS (QW),
		.SW    ($bits(side2_t))
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.num       (n2_s9),
		.den       (d2_s9),
		.side_in   (sd_s9),
		.out_valid (v_d2),
		.quo       (q2),
		.side_out  (sd2_raw)
	);

	assign sd_d2 = side2_t'(sd2_raw);

	always_comb begin
		if (sd_d2.pta && sd_d2.ptb) begin
			s_c = '0;
			t_c = '0;
		end else if (sd_d2.pta) begin
			s_c = '0;
			t_c = sd_d2.q1;
		end else if (sd_d2.ptb) begin
			s_c = sd_d2.q1;
			t_c = '0;
		end else begin
			case (sd_d2.mode)
				MODE_NEG: begin
					s_c = q2;
					t_c = '0;
				end
				MODE_OVER: begin
					s_c = q2;
					t_c = ONE_Q;
				end
				default: begin
					s_c = sd_d2.q1;
					t_c = q2;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sa_s10    <= sd_d2.sa;
		sb_s10    <= sd_d2.sb;
		ovl_s10   <= sd_d2.ovl;
		oa_s10[0] <= smul(sd_d2.da.x, s_c);
		oa_s10[1] <= smul(sd_d2.da.y, s_c);
		oa_s10[2] <= smul(sd_d2.da.z, s_c);
		ob_s10[0] <= smul(sd_d2.db.x, t_c);
		ob_s10[1] <= smul(sd_d2.db.y, t_c);
		ob_s10[2] <= smul(sd_d2.db.z, t_c);
	end

	always_ff @(posedge clk) begin
		pa_s11  <= '{point(sa_s10.x, oa_s10[0]), point(sa_s10.y, oa_s10[1]),
		            point(sa_s10.z, oa_s10[2])};
		pb_s11  <= '{point(sb_s10.x, ob_s10[0]), point(sb_s10.y, ob_s10[1]),
		            point(sb_s10.z, ob_s10[2])};
		ovl_s11 <= ovl_s10;
	end

	always_ff @(posedge clk) begin
		pa_s12  <= pa_s11;
		pb_s12  <= pb_s11;
		ovl_s12 <= ovl_s11;
		d_s12   <= '{dsub(pa_s11.x, pb_s11.x), dsub(pa_s11.y, pb_s11.y),
		            dsub(pa_s11.z, pb_s11.z)};
		mid_s12 <= '{midpoint(pa_s11.x, pb_s11.x), midpoint(pa_s11.y, pb_s11.y),
		            midpoint(pa_s11.z, pb_s11.z)};
	end

	always_ff @(posedge clk) begin
		pa_s13    <= pa_s12;
		pb_s13    <= pb_s12;
		mid_s13   <= mid_s12;
		ovl_s13   <= ovl_s12;
		sq_s13[0] <= pmul(d_s12.x, d_s12.x);
		sq_s13[1] <= pmul(d_s12.y, d_s12.y);
		sq_s13[2] <= pmul(d_s12.z, d_s12.z);
	end

	assign dsq_c = sq_s13[0] + sq_s13[1] + sq_s13[2];
	assign cd2_c = 32'(cfg_q.conflict_distance) * 32'(cfg_q.conflict_distance);
	assign ct2_c = 32'(cfg_q.crossing_tolerance) * 32'(cfg_q.crossing_tolerance);

	always_ff @(posedge clk) begin
		sd_s14.pa       <= pa_s13;
		sd_s14.pb       <= pb_s13;
		sd_s14.mid      <= mid_s13;
		sd_s14.conflict <= dsq_c < dot_t'(cd2_c);
		sd_s14.crossing <= (dsq_c < dot_t'(cd2_c)) && (dsq_c <= dot_t'(ct2_c));
		sd_s14.big      <= dsq_c[DOTW-1:SQW] != '0;
		sd_s14.ovl      <= ovl_s13;
		x_s14           <= dsq_c[SQW-1:0];
	end

	spp_sqrt #(
		.XW (SQW),
		.SW ($bits(side3_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s14),
		.x_in      (x_s14),
		.side_in   (sd_s14),
		.out_valid (v_sq),
		.root      (root),
		.side_out  (sd3_raw)
	);

	assign sd_sq = side3_t'(sd3_raw);

	always_ff @(posedge clk) begin
		if (!sd_sq.ovl) begin
			result_q <= '{separation: '1, default: '0};
		end else begin
			result_q.conflict   <= sd_sq.conflict;
			result_q.crossing   <= sd_sq.crossing;
			result_q.separation <= sd_sq.big ? '1 : root;
			result_q.mid_x      <= sd_sq.conflict ? sd_sq.mid.x : '0;
			result_q.mid_y      <= sd_sq.conflict ? sd_sq.mid.y : '0;
			result_q.mid_z      <= sd_sq.conflict ? sd_sq.mid.z : '0;
			result_q.near_a_x   <= sd_sq.pa.x;
			result_q.near_a_y   <= sd_sq.pa.y;
			result_q.near_a_z   <= sd_sq.pa.z;
			result_q.near_b_x   <= sd_sq.pb.x;
			result_q.near_b_y   <= sd_sq.pb.y;
			result_q.near_b_z   <= sd_sq.pb.z;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item did not finish in the fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching item");

	a_cross_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.crossing) |-> result.conflict)
		else $error("crossing without conflict");

	a_mid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.conflict) |->
		(result.mid_x == '0 && result.mid_y == '0 && result.mid_z == '0))
		else $error("midpoint set without conflict");

endmodule
